// ===== rtl/core/multi_pattern_string_matcher_core_assert.svh =====
// ============================================================================
// Assertion macros for the multi-pattern string matcher core
// Concurrent checks on i_clk, disabled while i_rst_n is low.
// ============================================================================
`ifndef MULTI_PATTERN_STRING_MATCHER_CORE_ASSERT_SVH
`define MULTI_PATTERN_STRING_MATCHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define MPSM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("mpsm assertion failed");
`define MPSM_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
`else
`define MPSM_ASSERT(lbl, prop)
`define MPSM_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/mpsm_pkg.sv =====
// ============================================================================
// mpsm_pkg
// Shared constants and codes of the multi-pattern string matcher.
// ============================================================================
package mpsm_pkg;

    localparam int NUM_STATES   = 256;
    localparam int MAX_KEYWORDS = 16;
    localparam int MAX_RESULTS  = 16;

    localparam int ST_W  = $clog2(NUM_STATES);      // node index
    localparam int CNT_W = ST_W + 1;                // node count, holds NUM_STATES
    localparam int SYM_W = 8;
    localparam int KW_W  = $clog2(MAX_KEYWORDS) + 1; // keyword index plus one
    localparam int IDX_W = 4;
    localparam int RES_W = $clog2(MAX_RESULTS) + 1;

    // trie word: {depth, symbol, parent}
    localparam int A_W = 2 * ST_W + SYM_W;
    // link word: {fail, keyword}
    localparam int B_W = ST_W + KW_W;

    localparam logic KIND_MATCH  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_KEY   = 2'd1,
        ACT_BUILD = 2'd2,
        ACT_TEXT  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_KW_FULL   = 2'd2,
        STAT_NOT_BUILT = 2'd3
    } t_status;

endpackage

// ===== rtl/core/mpsm_ram.sv =====
// ============================================================================
// mpsm_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module mpsm_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/multi_pattern_string_matcher_core.sv =====
// ============================================================================
// multi_pattern_string_matcher_core
// Aho-Corasick keyword matcher built around two node memories.
// ============================================================================
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | i_valid / o_ready  | i_action i_symbol i_keyword_end i_text_start
//  out     | o_valid / i_ready  | o_kind o_keyword_index o_status o_last
//
//  One item at a time. Every child lookup is a scan of the trie memory.
//  Keyword byte: one lookup, then the node write. Text byte: (failure moves
//  + 1) lookups, then a walk of the output chain with one report per keyword
//  node. Build: per depth level a pass over all nodes, each node of that depth
//  costing one lookup per failure move.
//  Reset is synchronous; no clearing pass, the node count bounds every scan.
//  A stalled output holds the engine in its emit step; one beat waits in the
//  output register while the next input beat is taken.
// ============================================================================
`include "multi_pattern_string_matcher_core_assert.svh"

module multi_pattern_string_matcher_core
    import mpsm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_action,
    input  logic [SYM_W-1:0] i_symbol,
    input  logic             i_keyword_end,
    input  logic             i_text_start,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_kind,
    output logic [IDX_W-1:0] o_keyword_index,
    output logic [1:0]       o_status,
    output logic             o_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_EMIT, S_SCAN, S_KW1, S_KWWR,
        S_BL_LVL, S_BL_RD, S_BL_CHK, S_BL_F, S_BL_T, S_BL_WR0, S_BL_WR1,
        S_T_CHK, S_T_F, S_W_CHK, S_W_DAT
    } t_state;

    // ---- memories: trie entries and failure/keyword links
    logic             a_we;
    logic [ST_W-1:0]  a_waddr, a_raddr;
    logic [A_W-1:0]   a_wdata, a_rd;
    logic             b_we;
    logic [ST_W-1:0]  b_waddr, b_raddr;
    logic [B_W-1:0]   b_wdata, b_rd;

    mpsm_ram #(.WIDTH(A_W), .DEPTH(NUM_STATES)) u_trie_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rd)
    );

    mpsm_ram #(.WIDTH(B_W), .DEPTH(NUM_STATES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rd)
    );

    logic [ST_W-1:0]  a_par, a_dep, b_fail;
    logic [SYM_W-1:0] a_sym;
    logic [KW_W-1:0]  b_kw;

    assign a_par  = a_rd[ST_W-1:0];
    assign a_sym  = a_rd[ST_W+SYM_W-1:ST_W];
    assign a_dep  = a_rd[A_W-1:ST_W+SYM_W];
    assign b_kw   = b_rd[KW_W-1:0];
    assign b_fail = b_rd[B_W-1:KW_W];

    // ---- registers
    t_state           r_state, n_state, r_ret, n_ret, r_e_ret, n_e_ret;
    logic             r_e_kind, n_e_kind, r_e_last, n_e_last;
    logic [IDX_W-1:0] r_e_idx, n_e_idx;
    t_status          r_e_status, n_e_status;
    logic             r_out_valid, n_out_valid, r_out_kind, n_out_kind;
    logic             r_out_last, n_out_last;
    logic [IDX_W-1:0] r_out_idx, n_out_idx;
    t_status          r_out_status, n_out_status;
    logic [CNT_W-1:0] r_node_cnt, n_node_cnt, r_ia, n_ia, r_bc, n_bc, r_lvl, n_lvl;
    logic [KW_W-1:0]  r_kw_cnt, n_kw_cnt;
    logic [ST_W-1:0]  r_cursor, n_cursor, r_cur_depth, n_cur_depth;
    logic [ST_W-1:0]  r_max_depth, n_max_depth, r_match, n_match;
    logic             r_built, n_built;
    logic [SYM_W-1:0] r_sym, n_sym, r_key_s, n_key_s;
    logic             r_kend, n_kend;
    logic [ST_W-1:0]  r_key_p, n_key_p, r_ca, n_ca, r_res, n_res, r_res_depth, n_res_depth;
    logic             r_cv, n_cv;
    logic [ST_W-1:0]  r_c, n_c, r_f, n_f, r_fail_v, n_fail_v, r_s, n_s;
    logic [RES_W-1:0] r_nres, n_nres;
    logic             r_pend_v, n_pend_v;
    logic [IDX_W-1:0] r_pend_idx, n_pend_idx;

    // ---- helpers
    logic             out_free, issue, create, kw_ok;
    logic [ST_W-1:0]  kc, kd, s0;

    assign out_free = !r_out_valid || i_ready;
    assign issue    = r_ia < r_node_cnt;
    assign create   = (r_res == '0);
    assign kc       = create ? r_node_cnt[ST_W-1:0] : r_res;
    assign kd       = create ? ST_W'(r_cur_depth + 1'b1) : r_res_depth;
    assign kw_ok    = r_kw_cnt < KW_W'(MAX_KEYWORDS);
    assign s0       = i_text_start ? '0 : r_match;

    always_comb begin
        n_state = r_state;       n_ret = r_ret;           n_e_ret = r_e_ret;
        n_e_kind = r_e_kind;     n_e_last = r_e_last;     n_e_idx = r_e_idx;
        n_e_status = r_e_status;
        n_out_valid = r_out_valid && !i_ready;
        n_out_kind = r_out_kind; n_out_last = r_out_last; n_out_idx = r_out_idx;
        n_out_status = r_out_status;
        n_node_cnt = r_node_cnt; n_ia = r_ia;             n_bc = r_bc;
        n_lvl = r_lvl;           n_kw_cnt = r_kw_cnt;     n_cursor = r_cursor;
        n_cur_depth = r_cur_depth; n_max_depth = r_max_depth; n_match = r_match;
        n_built = r_built;       n_sym = r_sym;           n_key_s = r_key_s;
        n_kend = r_kend;         n_key_p = r_key_p;       n_ca = r_ca;
        n_res = r_res;           n_res_depth = r_res_depth; n_cv = r_cv;
        n_c = r_c;               n_f = r_f;               n_fail_v = r_fail_v;
        n_s = r_s;               n_nres = r_nres;         n_pend_v = r_pend_v;
        n_pend_idx = r_pend_idx;
        a_we = 1'b0; a_waddr = '0; a_wdata = '0; a_raddr = '0;
        b_we = 1'b0; b_waddr = '0; b_wdata = '0; b_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sym  = i_symbol;
                    n_kend = i_keyword_end;
                    // status answer by default; paths below override
                    n_e_kind = KIND_STATUS; n_e_idx = '0; n_e_status = STAT_OK;
                    n_e_last = 1'b1;        n_e_ret = S_IDLE;
                    case (t_action'(i_action))
                        ACT_CLEAR: begin
                            n_node_cnt = CNT_W'(1); n_kw_cnt = '0;
                            n_cursor = '0; n_cur_depth = '0; n_max_depth = '0;
                            n_match = '0; n_built = 1'b0;
                            n_state = S_EMIT;
                        end
                        ACT_KEY: begin
                            n_built = 1'b0;
                            n_key_p = r_cursor; n_key_s = i_symbol;
                            n_ia = CNT_W'(1); n_cv = 1'b0; n_ret = S_KW1;
                            n_state = S_SCAN;
                        end
                        ACT_BUILD: begin
                            // depth-one nodes always fail to root
                            n_lvl = CNT_W'(2);
                            n_state = S_BL_LVL;
                        end
                        ACT_TEXT: begin
                            if (!r_built) begin
                                n_e_status = STAT_NOT_BUILT;
                                n_state = S_EMIT;
                            end else begin
                                n_s = s0;
                                n_key_p = s0; n_key_s = i_symbol;
                                n_ia = CNT_W'(1); n_cv = 1'b0; n_ret = S_T_CHK;
                                n_state = S_SCAN;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;     n_out_kind = r_e_kind;
                    n_out_idx = r_e_idx;    n_out_status = r_e_status;
                    n_out_last = r_e_last;  n_state = r_e_ret;
                end
            end

            // child lookup: linear sweep over nodes 1..node_count-1
            S_SCAN: begin
                a_raddr = r_ia[ST_W-1:0];
                n_cv = issue;
                n_ca = r_ia[ST_W-1:0];
                if (issue) begin
                    n_ia = r_ia + 1'b1;
                end
                if (r_cv && a_par == r_key_p && a_sym == r_key_s) begin
                    n_res = r_ca; n_res_depth = a_dep;
                    n_cv = 1'b0; n_state = r_ret;
                end else if (!r_cv && !issue) begin
                    n_res = '0; n_state = r_ret;
                end
            end

            S_KW1: begin
                n_e_kind = KIND_STATUS; n_e_idx = '0; n_e_status = STAT_OK;
                n_e_last = 1'b1;        n_e_ret = S_IDLE;
                if (create && r_node_cnt[ST_W]) begin
                    n_cursor = '0; n_cur_depth = '0;
                    n_e_status = STAT_FULL;
                    n_state = S_EMIT;
                end else begin
                    if (create) begin
                        a_we = 1'b1; a_waddr = kc; a_wdata = {kd, r_sym, r_cursor};
                        b_we = 1'b1; b_waddr = kc;
                        b_wdata = {{ST_W{1'b0}},
                                   (r_kend && kw_ok) ? KW_W'(r_kw_cnt + 1'b1) : {KW_W{1'b0}}};
                        n_node_cnt = r_node_cnt + 1'b1;
                        if (kd > r_max_depth) begin
                            n_max_depth = kd;
                        end
                    end
                    b_raddr = kc;
                    n_c = kc;
                    n_state = S_EMIT;
                    if (!r_kend) begin
                        n_cursor = kc; n_cur_depth = kd;
                    end else begin
                        n_cursor = '0; n_cur_depth = '0;
                        if (!kw_ok) begin
                            n_e_status = STAT_KW_FULL;
                        end else begin
                            n_kw_cnt = r_kw_cnt + 1'b1;
                            if (!create) begin
                                n_state = S_KWWR;
                            end
                        end
                    end
                end
            end

            // repeated keyword keeps its first index
            S_KWWR: begin
                if (b_kw == '0) begin
                    b_we = 1'b1; b_waddr = r_c; b_wdata = {b_fail, r_kw_cnt};
                end
                n_state = S_EMIT;
            end

            S_BL_LVL: begin
                if (r_lvl > {1'b0, r_max_depth}) begin
                    n_match = '0; n_built = 1'b1;
                    n_e_kind = KIND_STATUS; n_e_idx = '0; n_e_status = STAT_OK;
                    n_e_last = 1'b1;        n_e_ret = S_IDLE;
                    n_state = S_EMIT;
                end else begin
                    n_bc = CNT_W'(1);
                    n_state = S_BL_RD;
                end
            end

            S_BL_RD: begin
                if (r_bc >= r_node_cnt) begin
                    n_lvl = r_lvl + 1'b1;
                    n_state = S_BL_LVL;
                end else begin
                    a_raddr = r_bc[ST_W-1:0];
                    n_state = S_BL_CHK;
                end
            end

            S_BL_CHK: begin
                if (a_dep == r_lvl[ST_W-1:0]) begin
                    n_c = r_bc[ST_W-1:0];
                    n_key_s = a_sym;
                    b_raddr = a_par;
                    n_state = S_BL_F;
                end else begin
                    n_bc = r_bc + 1'b1;
                    n_state = S_BL_RD;
                end
            end

            S_BL_F: begin
                n_f = b_fail;
                n_key_p = b_fail;
                n_ia = CNT_W'(1); n_cv = 1'b0; n_ret = S_BL_T;
                n_state = S_SCAN;
            end

            S_BL_T: begin
                if (r_res != '0) begin
                    n_fail_v = r_res; n_state = S_BL_WR0;
                end else if (r_f == '0) begin
                    n_fail_v = '0;    n_state = S_BL_WR0;
                end else begin
                    b_raddr = r_f;    n_state = S_BL_F;
                end
            end

            S_BL_WR0: begin
                b_raddr = r_c;
                n_state = S_BL_WR1;
            end

            S_BL_WR1: begin
                b_we = 1'b1; b_waddr = r_c; b_wdata = {r_fail_v, b_kw};
                n_bc = r_bc + 1'b1;
                n_state = S_BL_RD;
            end

            S_T_CHK: begin
                if (r_res != '0 || r_s == '0) begin
                    n_match = r_res; n_s = r_res;
                    n_nres = '0; n_pend_v = 1'b0;
                    n_state = S_W_CHK;
                end else begin
                    b_raddr = r_s;
                    n_state = S_T_F;
                end
            end

            S_T_F: begin
                n_s = b_fail;
                n_key_p = b_fail; n_key_s = r_sym;
                n_ia = CNT_W'(1); n_cv = 1'b0; n_ret = S_T_CHK;
                n_state = S_SCAN;
            end

            // output chain; one report is held back to learn its last flag
            S_W_CHK: begin
                if (r_s == '0 || r_nres == RES_W'(MAX_RESULTS)) begin
                    if (r_pend_v) begin
                        n_e_kind = KIND_MATCH; n_e_idx = r_pend_idx;
                        n_e_status = STAT_OK;  n_e_last = 1'b1; n_e_ret = S_IDLE;
                        n_pend_v = 1'b0;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    b_raddr = r_s;
                    n_state = S_W_DAT;
                end
            end

            S_W_DAT: begin
                n_s = b_fail;
                n_state = S_W_CHK;
                if (b_kw != '0) begin
                    n_nres = r_nres + 1'b1;
                    n_pend_v = 1'b1;
                    n_pend_idx = IDX_W'(b_kw - 1'b1);
                    if (r_pend_v) begin
                        n_e_kind = KIND_MATCH; n_e_idx = r_pend_idx;
                        n_e_status = STAT_OK;  n_e_last = 1'b0; n_e_ret = S_W_CHK;
                        n_state = S_EMIT;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_node_cnt <= CNT_W'(1);
            r_kw_cnt <= '0;
            r_cursor <= '0;
            r_cur_depth <= '0;
            r_max_depth <= '0;
            r_match <= '0;
            r_built <= 1'b0;
            r_cv <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            r_node_cnt <= n_node_cnt;
            r_kw_cnt <= n_kw_cnt;
            r_cursor <= n_cursor;
            r_cur_depth <= n_cur_depth;
            r_max_depth <= n_max_depth;
            r_match <= n_match;
            r_built <= n_built;
            r_cv <= n_cv;
            r_pend_v <= n_pend_v;
        end
        r_ret <= n_ret;           r_e_ret <= n_e_ret;
        r_e_kind <= n_e_kind;     r_e_last <= n_e_last;
        r_e_idx <= n_e_idx;       r_e_status <= n_e_status;
        r_out_kind <= n_out_kind; r_out_last <= n_out_last;
        r_out_idx <= n_out_idx;   r_out_status <= n_out_status;
        r_ia <= n_ia;             r_bc <= n_bc;           r_lvl <= n_lvl;
        r_sym <= n_sym;           r_key_s <= n_key_s;     r_kend <= n_kend;
        r_key_p <= n_key_p;       r_ca <= n_ca;
        r_res <= n_res;           r_res_depth <= n_res_depth;
        r_c <= n_c;               r_f <= n_f;             r_fail_v <= n_fail_v;
        r_s <= n_s;               r_nres <= n_nres;       r_pend_idx <= n_pend_idx;
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_keyword_index = r_out_idx;
    assign o_status        = r_out_status;
    assign o_last          = r_out_last;

    // ---- checks
    `MPSM_ASSERT(a_node_cnt_range, (r_node_cnt != '0) && (r_node_cnt <= CNT_W'(NUM_STATES)))
    `MPSM_ASSERT(a_kw_cnt_range, r_kw_cnt <= KW_W'(MAX_KEYWORDS))
    `MPSM_ASSERT_MSG(a_cursor_depth, r_cur_depth <= r_max_depth, "cursor deeper than trie")
    `MPSM_ASSERT(a_key_unbuilds, (i_valid && o_ready && i_action == ACT_KEY) |=> !r_built)

endmodule
